/* hdl/bilinear_elevation_nodata_defines.svh */
// Assertion macros for the bilinear elevation block.
// Used by the top level only; no other dependencies.
`ifndef BILINEAR_ELEVATION_NODATA_DEFINES_SVH
`define BILINEAR_ELEVATION_NODATA_DEFINES_SVH
`ifndef SYNTH
`define BED_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define BED_CHECK_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define BED_CHECK(label, prop, msg)
`define BED_CHECK_IMPL(label, ante, cons, msg)
`endif
`endif

/* hdl/bed_pkg.sv */
// Shared widths, constants and the divider beat type of the bilinear elevation block.
// No dependencies.
package bed_pkg;

	localparam int unsigned FRAC_W   = 8;
	localparam int unsigned SAMP_W   = 16;
	localparam int unsigned WGT_W    = 17;  // one corner weight, max 65536
	localparam int unsigned PROD_W   = 33;  // signed sample times weight
	localparam int unsigned SUM_W    = 33;  // weighted sum, |sum| <= 2^31
	localparam int unsigned MAG_W    = 32;
	localparam int unsigned NUM_W    = 41;  // 2*|sum|*256 + wsum
	localparam int unsigned QUOT_W   = 24;
	localparam int unsigned REM_W    = 18;  // remainder below 2*wsum
	localparam int unsigned ELEV_W   = 24;
	localparam int unsigned CORNERS  = 4;

	localparam logic [SAMP_W-1:0] NODATA_RESET = 16'h8000;

	// quotient bits resolved per divider stage; must divide QUOT_W, at most 8
	localparam int unsigned DIV_BITS_DEFAULT = 3;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [QUOT_W-1:0] num_lo;
		logic [REM_W-1:0]  den2;
		logic [QUOT_W-1:0] quot;
		logic              neg;
		logic              ok;
	} div_beat_t;

endpackage

/* hdl/bed_front.sv */
// Front end: no-data mask, corner weights, products and sums (three stages).
// Depends on bed_pkg.
module bed_front import bed_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [SAMP_W-1:0]        nodata_code,
	input  logic [FRAC_W-1:0]        frac_x,
	input  logic [FRAC_W-1:0]        frac_y,
	input  logic [SAMP_W-1:0]        sample_top_left,
	input  logic [SAMP_W-1:0]        sample_top_right,
	input  logic [SAMP_W-1:0]        sample_bottom_left,
	input  logic [SAMP_W-1:0]        sample_bottom_right,
	output logic                     out_valid,
	output logic signed [SUM_W-1:0]  sum,
	output logic [WGT_W-1:0]         wsum
);

	logic [CORNERS-1:0][SAMP_W-1:0] raw;
	logic [FRAC_W:0]                fx_c, fy_c, fx_e, fy_e;
	logic [CORNERS-1:0][WGT_W+1-1:0] w_full;
	logic [CORNERS-1:0][WGT_W-1:0]  w_mask;

	logic                           valid_s1, valid_s2, valid_s3;
	logic [CORNERS-1:0][SAMP_W-1:0] samp_s1;
	logic [CORNERS-1:0][WGT_W-1:0]  w_s1, w_s2;
	logic [CORNERS-1:0][PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]        sum_s3;
	logic [WGT_W-1:0]               wsum_s3;

	logic [CORNERS-1:0][PROD_W-1:0] prod_c;
	logic signed [SUM_W-1:0]        sum_c;
	logic [WGT_W-1:0]               wsum_c;

	assign raw  = {sample_bottom_right, sample_bottom_left, sample_top_right, sample_top_left};
	assign fx_e = {1'b0, frac_x};
	assign fy_e = {1'b0, frac_y};
	assign fx_c = (FRAC_W+1)'(1 << FRAC_W) - fx_e;
	assign fy_c = (FRAC_W+1)'(1 << FRAC_W) - fy_e;

	// weights in units of 1/65536; drop corners that hold the no-data code
	always_comb begin
		w_full[0] = fx_c * fy_c;
		w_full[1] = fx_e * fy_c;
		w_full[2] = fx_c * fy_e;
		w_full[3] = fx_e * fy_e;
		for (int i = 0; i < CORNERS; i++) begin
			w_mask[i] = (raw[i] != nodata_code) ? w_full[i][WGT_W-1:0] : '0;
		end
	end

	always_comb begin
		for (int i = 0; i < CORNERS; i++) begin
			prod_c[i] = $signed(samp_s1[i]) * $signed({1'b0, w_s1[i]});
		end
	end

	always_comb begin
		sum_c  = $signed(prod_s2[0]) + $signed(prod_s2[1])
		       + $signed(prod_s2[2]) + $signed(prod_s2[3]);
		wsum_c = w_s2[0] + w_s2[1] + w_s2[2] + w_s2[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		samp_s1 <= raw;
		w_s1    <= w_mask;
		prod_s2 <= prod_c;
		w_s2    <= w_s1;
		sum_s3  <= sum_c;
		wsum_s3 <= wsum_c;
	end

	assign out_valid = valid_s3;
	assign sum       = sum_s3;
	assign wsum      = wsum_s3;

endmodule

/* hdl/bed_div_step.sv */
// One registered stage of the restoring divider: resolves STEP_BITS quotient bits.
// Depends on bed_pkg.
module bed_div_step import bed_pkg::*; #(
	parameter int unsigned STEP_BITS = DIV_BITS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  div_beat_t in_beat,
	output logic      out_valid,
	output div_beat_t out_beat
);

	logic [REM_W-1:0]  r;
	logic [QUOT_W-1:0] n;
	logic [QUOT_W-1:0] q;
	logic [REM_W:0]    t;
	logic [REM_W:0]    d;
	div_beat_t         nxt;

	logic              valid_s1;
	div_beat_t         beat_s1;

	assign d = {1'b0, in_beat.den2};

	// shift in one dividend bit per step, subtract where the divisor fits
	always_comb begin
		r = in_beat.rem;
		n = in_beat.num_lo;
		q = in_beat.quot;
		t = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {r, n[QUOT_W-1]};
			n = {n[QUOT_W-2:0], 1'b0};
			if (t >= d) begin
				r = REM_W'(t - d);
				q = {q[QUOT_W-2:0], 1'b1};
			end else begin
				r = t[REM_W-1:0];
				q = {q[QUOT_W-2:0], 1'b0};
			end
		end
		nxt        = in_beat;
		nxt.rem    = r;
		nxt.num_lo = n;
		nxt.quot   = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		beat_s1 <= nxt;
	end

	assign out_valid = valid_s1;
	assign out_beat  = beat_s1;

endmodule

/* hdl/bilinear_elevation_nodata.sv */
// Top level of the bilinear elevation blend with no-data mask.
// Depends on bed_pkg, bed_front, bed_div_step and bilinear_elevation_nodata_defines.svh.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------------
//   input    | start, busy (always 0) | frac_x, frac_y, sample_* (four corners)
//   result   | done (one-cycle strobe)| elevation, valid_res
//   config   | cfg_valid, cfg_ready   | cfg_data (no-data code)
//
// One beat enters every cycle; busy never rises. The accepting edge loads the first of
// 5 + 24/DIV_BITS registers: three front-end stages, one prep stage, the divider chain
// of 24/DIV_BITS stages, and the output register. Done is the valid bit of the output
// register and rises once a beat has passed through all of them.
// The divider chain sets the depth: each stage resolves DIV_BITS quotient bits.
// Reset clears all valid bits and loads the no-data code with 0x8000. The result side
// cannot stall, so the pipeline always advances and nothing waits.
`include "bilinear_elevation_nodata_defines.svh"
module bilinear_elevation_nodata import bed_pkg::*; #(
	parameter int unsigned DIV_BITS = DIV_BITS_DEFAULT  // 1, 2, 3, 4, 6 or 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [FRAC_W-1:0]        frac_x,
	input  logic [FRAC_W-1:0]        frac_y,
	input  logic [SAMP_W-1:0]        sample_top_left,
	input  logic [SAMP_W-1:0]        sample_top_right,
	input  logic [SAMP_W-1:0]        sample_bottom_left,
	input  logic [SAMP_W-1:0]        sample_bottom_right,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [SAMP_W-1:0]        cfg_data,
	output logic                     done,
	output logic signed [ELEV_W-1:0] elevation,
	output logic                     valid_res
);

	localparam int unsigned DIV_STAGES = QUOT_W / DIV_BITS;
	localparam logic signed [ELEV_W-1:0] ELEV_MAX = 24'sh7FFF00;

	logic [SAMP_W-1:0]       nodata_q;

	logic                    front_valid;
	logic signed [SUM_W-1:0] front_sum;
	logic [WGT_W-1:0]        front_wsum;

	logic                    neg_c;
	logic [SUM_W-1:0]        mag_full;
	logic [NUM_W-1:0]        num_c;
	div_beat_t               prep_c;

	logic                    valid_s4;
	div_beat_t               beat_s4;

	logic [DIV_STAGES:0]     div_valid;
	div_beat_t               div_beat [DIV_STAGES+1];

	div_beat_t               last;
	logic [QUOT_W-1:0]       res_mag;
	logic [ELEV_W-1:0]       res_signed;

	logic                    done_q;
	logic                    valid_res_q;
	logic [ELEV_W-1:0]       elev_q;

	// every cycle takes a beat; the receiver cannot hold results off
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration register: the user must write it only while the pipeline is empty; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodata_q <= NODATA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			nodata_q <= cfg_data;
		end
	end

	// stages 1..3: mask, weights, products, sums
	bed_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (start && !busy),
		.nodata_code         (nodata_q),
		.frac_x              (frac_x),
		.frac_y              (frac_y),
		.sample_top_left     (sample_top_left),
		.sample_top_right    (sample_top_right),
		.sample_bottom_left  (sample_bottom_left),
		.sample_bottom_right (sample_bottom_right),
		.out_valid           (front_valid),
		.sum                 (front_sum),
		.wsum                (front_wsum)
	);

	// stage 4: fold rounding into the dividend, q = (2*|sum|*256 + w) / (2*w).
	// The quotient fits 24 bits, so the top 17 dividend bits start below the divisor.
	always_comb begin
		neg_c         = front_sum[SUM_W-1];
		mag_full      = neg_c ? SUM_W'(-front_sum) : SUM_W'(front_sum);
		num_c         = {mag_full[MAG_W-1:0], 9'b0} + NUM_W'(front_wsum);
		prep_c.rem    = REM_W'(num_c[NUM_W-1:QUOT_W]);
		prep_c.num_lo = num_c[QUOT_W-1:0];
		prep_c.den2   = {front_wsum, 1'b0};
		prep_c.quot   = '0;
		prep_c.neg    = neg_c;
		// no weight left to blend on: mark the beat as no data
		prep_c.ok     = (front_wsum != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= front_valid;
		end
	end

	always_ff @(posedge clk) begin
		beat_s4 <= prep_c;
	end

	assign div_valid[0] = valid_s4;
	assign div_beat[0]  = beat_s4;

	// divider chain: each stage resolves DIV_BITS quotient bits
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		bed_div_step #(
			.STEP_BITS (DIV_BITS)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_valid[g]),
			.in_beat   (div_beat[g]),
			.out_valid (div_valid[g+1]),
			.out_beat  (div_beat[g+1])
		);
	end

	// restore the sign; magnitude 2^23 negates to the most negative code
	assign last       = div_beat[DIV_STAGES];
	assign res_mag    = last.quot;
	assign res_signed = last.neg ? ELEV_W'(-res_mag) : ELEV_W'(res_mag);

	// output register: hold zero with valid_res low for beats without data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			valid_res_q <= 1'b0;
		end else begin
			done_q      <= div_valid[DIV_STAGES];
			valid_res_q <= div_valid[DIV_STAGES] && last.ok;
		end
	end

	always_ff @(posedge clk) begin
		elev_q <= last.ok ? res_signed : '0;
	end

	assign done      = done_q;
	assign valid_res = valid_res_q;
	assign elevation = elev_q;

	// a beat without data must read as zero
	`BED_CHECK_IMPL(a_nodata_zero, done && !valid_res, elevation == '0, "no-data result is not zero")
	// the divider must leave a remainder below its divisor on live beats
	`BED_CHECK_IMPL(a_rem_below_den, div_valid[DIV_STAGES] && last.ok, last.rem < last.den2, "divider remainder out of range")
	// a weighted mean never exceeds the largest possible corner height, 0x7fff with 8 fraction bits
	`BED_CHECK_IMPL(a_elev_range, done && valid_res, elevation <= ELEV_MAX, "elevation above corner range")
	// valid_res only rides on a result strobe
	`BED_CHECK_IMPL(a_valid_on_done, valid_res, done, "valid_res without done")

endmodule

/* tb/sv/tb_bilinear_elevation_nodata.sv */
`timescale 1ns / 100ps
// Self-checking testbench for bilinear_elevation_nodata: blend of four corner heights with a
// no-data mask, checked result by result against a predictor kept inside the bench.
// Depends on bed_pkg and the RTL of the block; nothing else.
module tb_bilinear_elevation_nodata;
	import bed_pkg::*;

	// One grid cell as the block sees it; field order matches the port order.
	typedef struct packed {
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
		logic [SAMP_W-1:0] tl;
		logic [SAMP_W-1:0] tr;
		logic [SAMP_W-1:0] bl;
		logic [SAMP_W-1:0] br;
	} cell_t;

	// One blended height as it leaves the block.
	typedef struct packed {
		logic signed [ELEV_W-1:0] elevation;
		logic                     valid_res;
	} height_t;

	localparam int unsigned RANDOM_PHASES  = 7;
	localparam int unsigned CELLS_PER_PHASE = 175;
	localparam int unsigned TAIL_CYCLES    = 40;   // pipeline depth is 13 at the default
	localparam int unsigned REPORT_LIMIT   = 10;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [FRAC_W-1:0] frac_x = '0;
	logic [FRAC_W-1:0] frac_y = '0;
	logic [SAMP_W-1:0] sample_top_left = '0;
	logic [SAMP_W-1:0] sample_top_right = '0;
	logic [SAMP_W-1:0] sample_bottom_left = '0;
	logic [SAMP_W-1:0] sample_bottom_right = '0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [SAMP_W-1:0] cfg_data = '0;
	logic              done;
	logic signed [ELEV_W-1:0] elevation;
	logic              valid_res;

	// Cells waiting to be driven, and heights the block still owes us.
	cell_t   cells_to_send[$];
	height_t heights_due[$];
	cell_t   next_cell;
	height_t want;

	// Predictor's own copy of the no-data register.
	logic [SAMP_W-1:0] nodata_now = NODATA_RESET;

	// Handshake echoes: set at the rising edge, read by the falling-edge driver.
	logic cell_taken = 1'b0;
	logic cfg_taken = 1'b0;

	// Suppress sender idling for one whole phase.
	logic quiet_run = 1'b0;

	int unsigned mismatch_count = 0;
	int unsigned results_checked = 0;
	int unsigned blank_results = 0;
	int unsigned codes_written = 0;

	bilinear_elevation_nodata u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.frac_x              (frac_x),
		.frac_y              (frac_y),
		.sample_top_left     (sample_top_left),
		.sample_top_right    (sample_top_right),
		.sample_bottom_left  (sample_bottom_left),
		.sample_bottom_right (sample_bottom_right),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_data            (cfg_data),
		.done                (done),
		.elevation           (elevation),
		.valid_res           (valid_res)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Expected height of one cell: weight each corner bilinearly (units of 1/65536), drop the
	// corners that carry the no-data code, renormalize by the surviving weight and round to
	// nearest with 8 fraction bits, ties away from zero. No surviving weight means no height.
	function automatic height_t blend_height(input cell_t c, input logic [SAMP_W-1:0] code);
		logic [SAMP_W-1:0] raw [CORNERS];
		longint            wgt [CORNERS];
		longint            fx;
		longint            fy;
		longint            acc;
		longint            wsum;
		longint            num;
		longint            mag;
		longint            quo;
		height_t           h;
		fx = longint'(c.fx);
		fy = longint'(c.fy);
		wgt[0] = (256 - fx) * (256 - fy);
		wgt[1] = fx * (256 - fy);
		wgt[2] = (256 - fx) * fy;
		wgt[3] = fx * fy;
		raw[0] = c.tl;
		raw[1] = c.tr;
		raw[2] = c.bl;
		raw[3] = c.br;
		acc = 0;
		wsum = 0;
		for (int i = 0; i < CORNERS; i++) begin
			if (raw[i] != code) begin
				acc += longint'($signed(raw[i])) * wgt[i];
				wsum += wgt[i];
			end
		end
		if (wsum == 0) begin
			h.elevation = '0;
			h.valid_res = 1'b0;
		end else begin
			num = acc * 256;
			mag = (num < 0) ? -num : num;
			quo = (2 * mag + wsum) / (2 * wsum);
			if (num < 0)
				quo = -quo;
			h.elevation = quo[ELEV_W-1:0];
			h.valid_res = 1'b1;
		end
		return h;
	endfunction

	function automatic void add_cell(input logic [FRAC_W-1:0] fx, input logic [FRAC_W-1:0] fy,
			input logic [SAMP_W-1:0] tl, input logic [SAMP_W-1:0] tr,
			input logic [SAMP_W-1:0] bl, input logic [SAMP_W-1:0] br);
		cells_to_send.push_back(cell_t'({fx, fy, tl, tr, bl, br}));
	endfunction

	// Offsets lean toward the cell edges, where corner weights vanish.
	function automatic logic [FRAC_W-1:0] pick_frac();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return FRAC_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Hit the no-data code often so that every mask pattern turns up.
	function automatic logic [SAMP_W-1:0] pick_sample(input logic [SAMP_W-1:0] code);
		case ($urandom_range(0, 9))
			0, 1, 2: return code;
			3: begin
				case ($urandom_range(0, 3))
					0: return 16'h0000;
					1: return 16'h7fff;
					2: return 16'h8000;
					default: return 16'hffff;
				endcase
			end
			default: return SAMP_W'($urandom);
		endcase
	endfunction

	task automatic queue_random_cells(input int unsigned count, input logic [SAMP_W-1:0] code);
		repeat (count) begin
			add_cell(pick_frac(), pick_frac(), pick_sample(code), pick_sample(code),
				pick_sample(code), pick_sample(code));
		end
	endtask

	// Hold until every queued cell has been taken and every height has come back.
	// Sample at the rising edge, where neither the driver nor the queue moves.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (cells_to_send.size() != 0 || start || heights_due.size() != 0);
	endtask

	// Write the no-data register through its own channel; the block is idle here.
	task automatic write_nodata(input logic [SAMP_W-1:0] code);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= code;
		do
			@(negedge clk);
		while (!cfg_taken);
		cfg_valid <= 1'b0;
		codes_written++;
	endtask

	// Driver: present one cell per beat at the falling edge; advance once the previous
	// rising edge took the beat. Idle about 15 beats in a hundred unless in the quiet phase.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || cell_taken) begin
			if (cells_to_send.size() != 0 && (quiet_run || $urandom_range(0, 99) >= 15)) begin
				next_cell = cells_to_send.pop_front();
				frac_x <= next_cell.fx;
				frac_y <= next_cell.fy;
				sample_top_left <= next_cell.tl;
				sample_top_right <= next_cell.tr;
				sample_bottom_left <= next_cell.bl;
				sample_bottom_right <= next_cell.br;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: at each rising edge check a strobed height against the oldest expectation,
	// then predict the height of a cell taken at this same edge. Track register writes so
	// the predictor follows the block.
	always @(posedge clk) begin
		cell_taken <= arst_n && start && !busy;
		cfg_taken <= arst_n && cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				nodata_now <= cfg_data;
			if (done) begin
				results_checked++;
				if (valid_res === 1'b0)
					blank_results++;
				if (heights_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: height %0d valid %b strobed with nothing expected",
							$realtime, elevation, valid_res);
				end else begin
					want = heights_due.pop_front();
					if (elevation !== want.elevation || valid_res !== want.valid_res) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("%0t: height %0d valid %b, expected %0d valid %b",
								$realtime, elevation, valid_res, want.elevation,
								want.valid_res);
					end
				end
			end
			if (start && !busy)
				heights_due.push_back(blend_height(cell_t'({frac_x, frac_y, sample_top_left,
					sample_top_right, sample_bottom_left, sample_bottom_right}), nodata_now));
		end
	end

	// Stimulus: directed cells under three no-data codes, then random phases.
	initial begin
		logic [SAMP_W-1:0] code;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset code 0x8000: height extremes, all no-data, data only at zero-weight corners.
		add_cell(8'd0, 8'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		add_cell(8'd255, 8'd255, 16'h8001, 16'h8001, 16'h8001, 16'h8001);
		add_cell(8'd255, 8'd255, 16'h7fff, 16'h8001, 16'h8001, 16'h7fff);
		add_cell(8'd0, 8'd0, 16'h8000, 16'h1234, 16'h5678, 16'h9abc);
		add_cell(8'd0, 8'd128, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		add_cell(8'd77, 8'd0, 16'h0001, 16'h0002, 16'h8000, 16'h8000);
		add_cell(8'd128, 8'd128, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		add_cell(8'd255, 8'd0, 16'h8000, 16'h0001, 16'h8000, 16'h8000);
		add_cell(8'd128, 8'd128, 16'h7fff, 16'h8001, 16'h0000, 16'hffff);
		add_cell(8'd1, 8'd1, 16'hffff, 16'h0001, 16'h7fff, 16'h8001);
		add_cell(8'd255, 8'd255, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
		add_cell(8'd37, 8'd200, 16'h1234, 16'h8000, 16'hfedc, 16'h0f0f);
		add_cell(8'd170, 8'd85, 16'haaaa, 16'h5555, 16'h5555, 16'haaaa);
		wait_drained();

		// Code 0x0000 frees the most negative height.
		write_nodata(16'h0000);
		add_cell(8'd0, 8'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		add_cell(8'd128, 8'd128, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		add_cell(8'd200, 8'd50, 16'h8000, 16'h7fff, 16'h0000, 16'hffff);
		add_cell(8'd0, 8'd255, 16'h7fff, 16'h0000, 16'h0000, 16'h8000);
		wait_drained();

		// Code 0xffff: top of the raw range marks missing data.
		write_nodata(16'hffff);
		add_cell(8'd0, 8'd255, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		add_cell(8'd255, 8'd255, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
		add_cell(8'd255, 8'd255, 16'hffff, 16'hffff, 16'hffff, 16'h8000);
		add_cell(8'd255, 8'd0, 16'h7fff, 16'hffff, 16'h0000, 16'h0000);
		wait_drained();

		// Random phases, each under its own code; the third runs without sender idling.
		for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: code = NODATA_RESET;
				1: code = 16'h7fff;
				3: code = 16'h0001;
				5: code = 16'hffff;
				6: code = 16'h0000;
				default: code = SAMP_W'($urandom_range(0, 65535));
			endcase
			write_nodata(code);
			quiet_run <= (phase == 2);
			queue_random_cells(CELLS_PER_PHASE, code);
			wait_drained();
		end

		// Let the pipeline run dry, then check that nothing is still owed.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (heights_due.size() != 0) begin
			mismatch_count += heights_due.size();
			$display("%0d expected heights never arrived", heights_due.size());
		end
		$display("Checked %0d heights (%0d without data) under %0d no-data codes.",
			results_checked, blank_results, codes_written + 1);
		$display("Mismatches: %0d.", mismatch_count);
		if (mismatch_count == 0) begin
			$display("bilinear_elevation_nodata regression: pass");
		end else begin
			$display("bilinear_elevation_nodata regression: fail");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#3_000_000;
		$display("Timed out with %0d cells unsent and %0d heights owed.",
			cells_to_send.size(), heights_due.size());
		$display("bilinear_elevation_nodata regression: fail");
		$finish;
	end

endmodule
